@@ design/pid_controller_step_macros.svh @@
// Assertion macros shared by the pid_controller_step checkers
`ifndef PID_CONTROLLER_STEP_MACROS_SVH
`define PID_CONTROLLER_STEP_MACROS_SVH

// check on every clock edge outside reset
`define PID_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// check on every clock edge, reset included
`define PID_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ design/pid_pkg.sv @@
// Shared types and constants for the PID controller step block
package pid_pkg;

    localparam int DATA_WIDTH_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int IN_WIDTH        = 32;
    localparam int OUT_WIDTH       = 32;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int MAX_INT_WIDTH   = 31;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_RESET  = 1'b1
    } op_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_KP           = 3'd0,
        CFG_KI           = 3'd1,
        CFG_KD           = 3'd2,
        CFG_INT_LIMIT    = 3'd3,
        CFG_USE_D_TERM   = 3'd4,
        CFG_USE_I_TERM   = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic valid;
        logic reset_op;
        logic d_en;
    } pid_ctl_t;

endpackage

@@ design/pid_controller_step.sv @@
// Top level of the PID controller step: configuration registers and the three-register pipeline
//
//  channel  dir  handshake            payload
//  s_       in   s_valid / s_ready    s_operation, s_error_sample
//  m_       out  m_valid / m_ready    m_drive_value
//  cfg_     in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle unless m_ready stalls; a beat passes input, product and result registers.
// The integral add and clamp in the result stage and the sample history in the input stage
// are the loops, each closed through its own register.
// A reset event travels the pipeline in order and gives no result beat.
// With m_ready low the pipeline holds up to three items before s_ready falls.
// Reset clears the integral, the sample history and every valid flag; cfg_ready is always high.
module pid_controller_step
    import pid_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_operation,
    input  logic signed [IN_WIDTH-1:0] s_error_sample,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [OUT_WIDTH-1:0] m_drive_value,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    logic signed [CFG_DATA_WIDTH-1:0] kp_reg;
    logic signed [CFG_DATA_WIDTH-1:0] ki_reg;
    logic signed [CFG_DATA_WIDTH-1:0] kd_reg;
    logic [MAX_INT_WIDTH-1:0]         int_limit_reg;
    logic                             use_d_term_reg;
    logic                             use_i_term_reg;

    pid_ctl_t                     ctl_in;
    pid_ctl_t                     ctl_mult;
    logic                         mult_ready;
    logic                         accum_ready;
    logic signed [DATA_WIDTH-1:0] error_q;
    logic signed [DATA_WIDTH-1:0] diff_q;
    logic signed [DATA_WIDTH-1:0] p_term;
    logic signed [DATA_WIDTH-1:0] i_term;
    logic signed [DATA_WIDTH-1:0] d_term;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg         <= '0;
            ki_reg         <= '0;
            kd_reg         <= '0;
            int_limit_reg  <= '1;
            use_d_term_reg <= 1'b1;
            use_i_term_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_KP:         kp_reg         <= $signed(cfg_data);
                CFG_KI:         ki_reg         <= $signed(cfg_data);
                CFG_KD:         kd_reg         <= $signed(cfg_data);
                CFG_INT_LIMIT:  int_limit_reg  <= cfg_data[MAX_INT_WIDTH-1:0];
                CFG_USE_D_TERM: use_d_term_reg <= cfg_data[0];
                CFG_USE_I_TERM: use_i_term_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    pid_input_stage #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_input (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_error_sample(s_error_sample),
        .use_d_term    (use_d_term_reg),
        .next_ready    (mult_ready),
        .ctl           (ctl_in),
        .error_out     (error_q),
        .diff_out      (diff_q)
    );

    pid_mult_stage #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (ctl_in),
        .in_ready  (mult_ready),
        .error_in  (error_q),
        .diff_in   (diff_q),
        .kp        (kp_reg),
        .ki        (ki_reg),
        .kd        (kd_reg),
        .next_ready(accum_ready),
        .ctl       (ctl_mult),
        .p_term    (p_term),
        .i_term    (i_term),
        .d_term    (d_term)
    );

    pid_accum_stage #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_accum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_ctl       (ctl_mult),
        .in_ready     (accum_ready),
        .p_term       (p_term),
        .i_term       (i_term),
        .d_term       (d_term),
        .int_limit    (int_limit_reg),
        .use_i_term   (use_i_term_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_drive_value(m_drive_value)
    );

endmodule

@@ design/pid_input_stage.sv @@
// Input register: error saturation, error difference and sample history
module pid_input_stage
    import pid_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_operation,
    input  logic signed [IN_WIDTH-1:0]   s_error_sample,
    input  logic                         use_d_term,
    input  logic                         next_ready,
    output pid_ctl_t                     ctl,
    output logic signed [DATA_WIDTH-1:0] error_out,
    output logic signed [DATA_WIDTH-1:0] diff_out
);

    localparam int XW = (DATA_WIDTH > IN_WIDTH ? DATA_WIDTH : IN_WIDTH) + 2;
    localparam logic signed [XW-1:0] VMAX_X =
        {{(XW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [XW-1:0] VMIN_X = ~VMAX_X;

    function automatic logic signed [DATA_WIDTH-1:0] sat_w(input logic signed [XW-1:0] x);
        logic signed [DATA_WIDTH-1:0] r;
        if (x > VMAX_X) begin
            r = VMAX_X[DATA_WIDTH-1:0];
        end else if (x < VMIN_X) begin
            r = VMIN_X[DATA_WIDTH-1:0];
        end else begin
            r = x[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    pid_ctl_t                     ctl_reg;
    pid_ctl_t                     ctl_next;
    logic signed [DATA_WIDTH-1:0] error_reg;
    logic signed [DATA_WIDTH-1:0] diff_reg;
    logic signed [DATA_WIDTH-1:0] prev_error_reg;
    logic                         have_prev_reg;
    logic signed [DATA_WIDTH-1:0] error_sat;
    logic signed [DATA_WIDTH-1:0] diff_sat;
    logic                         is_reset;
    logic                         accept;

    assign s_ready   = !ctl_reg.valid || next_ready;
    assign accept    = s_valid && s_ready;
    assign is_reset  = (op_t'(s_operation) == OP_RESET);
    assign error_sat = sat_w(XW'(s_error_sample));
    assign diff_sat  = sat_w(XW'(error_sat) - XW'(prev_error_reg));

    always_comb begin
        ctl_next.valid    = s_valid;
        ctl_next.reset_op = is_reset;
        ctl_next.d_en     = use_d_term && have_prev_reg && !is_reset;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg        <= '0;
            have_prev_reg  <= 1'b0;
            prev_error_reg <= '0;
        end else begin
            if (s_ready) begin
                ctl_reg <= ctl_next;
            end
            if (accept) begin
                if (is_reset) begin
                    have_prev_reg <= 1'b0;
                end else if (use_d_term) begin
                    have_prev_reg  <= 1'b1;
                    prev_error_reg <= error_sat;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            error_reg <= error_sat;
            diff_reg  <= diff_sat;
        end
    end

    assign ctl       = ctl_reg;
    assign error_out = error_reg;
    assign diff_out  = diff_reg;

endmodule

@@ design/pid_mult_stage.sv @@
// Product register: the three gain products, truncated toward zero and saturated
module pid_mult_stage
    import pid_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  pid_ctl_t                       in_ctl,
    output logic                           in_ready,
    input  logic signed [DATA_WIDTH-1:0]   error_in,
    input  logic signed [DATA_WIDTH-1:0]   diff_in,
    input  logic signed [CFG_DATA_WIDTH-1:0] kp,
    input  logic signed [CFG_DATA_WIDTH-1:0] ki,
    input  logic signed [CFG_DATA_WIDTH-1:0] kd,
    input  logic                           next_ready,
    output pid_ctl_t                       ctl,
    output logic signed [DATA_WIDTH-1:0]   p_term,
    output logic signed [DATA_WIDTH-1:0]   i_term,
    output logic signed [DATA_WIDTH-1:0]   d_term
);

    localparam int XW = (DATA_WIDTH > CFG_DATA_WIDTH ? DATA_WIDTH : CFG_DATA_WIDTH) + 2;
    localparam int PW = 2 * DATA_WIDTH;
    localparam logic signed [XW-1:0] VMAX_X =
        {{(XW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [XW-1:0] VMIN_X = ~VMAX_X;
    localparam logic [PW-1:0] LIM_NEG = PW'(1) << (DATA_WIDTH - 1);
    localparam logic [PW-1:0] LIM_POS = LIM_NEG - PW'(1);

    function automatic logic signed [DATA_WIDTH-1:0] sat_w(input logic signed [XW-1:0] x);
        logic signed [DATA_WIDTH-1:0] r;
        if (x > VMAX_X) begin
            r = VMAX_X[DATA_WIDTH-1:0];
        end else if (x < VMIN_X) begin
            r = VMIN_X[DATA_WIDTH-1:0];
        end else begin
            r = x[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] qmul(
        input logic signed [DATA_WIDTH-1:0] a,
        input logic signed [DATA_WIDTH-1:0] b
    );
        logic                  neg;
        logic [DATA_WIDTH-1:0] ma;
        logic [DATA_WIDTH-1:0] mb;
        logic [PW-1:0]         prod;
        logic [PW-1:0]         mag;
        logic [PW-1:0]         lim;
        neg  = a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
        ma   = a[DATA_WIDTH-1] ? DATA_WIDTH'(-a) : DATA_WIDTH'(a);
        mb   = b[DATA_WIDTH-1] ? DATA_WIDTH'(-b) : DATA_WIDTH'(b);
        prod = PW'(ma) * PW'(mb);
        mag  = prod >> FRAC_BITS;
        lim  = neg ? LIM_NEG : LIM_POS;
        if (mag > lim) begin
            mag = lim;
        end
        return neg ? DATA_WIDTH'(-mag) : DATA_WIDTH'(mag);
    endfunction

    pid_ctl_t                     ctl_reg;
    logic signed [DATA_WIDTH-1:0] p_reg;
    logic signed [DATA_WIDTH-1:0] i_reg;
    logic signed [DATA_WIDTH-1:0] d_reg;
    logic signed [DATA_WIDTH-1:0] kp_sat;
    logic signed [DATA_WIDTH-1:0] ki_sat;
    logic signed [DATA_WIDTH-1:0] kd_sat;

    assign in_ready = !ctl_reg.valid || next_ready;
    assign kp_sat   = sat_w(XW'(kp));
    assign ki_sat   = sat_w(XW'(ki));
    assign kd_sat   = sat_w(XW'(kd));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (in_ready) begin
            ctl_reg <= in_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_ctl.valid) begin
            p_reg <= qmul(kp_sat, error_in);
            i_reg <= qmul(ki_sat, error_in);
            d_reg <= qmul(kd_sat, diff_in);
        end
    end

    assign ctl    = ctl_reg;
    assign p_term = p_reg;
    assign i_term = i_reg;
    assign d_term = d_reg;

endmodule

@@ design/pid_accum_stage.sv @@
// Result register: clamped integral, saturating sums and the drive value beat
module pid_accum_stage
    import pid_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  pid_ctl_t                     in_ctl,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] p_term,
    input  logic signed [DATA_WIDTH-1:0] i_term,
    input  logic signed [DATA_WIDTH-1:0] d_term,
    input  logic [MAX_INT_WIDTH-1:0]     int_limit,
    input  logic                         use_i_term,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [OUT_WIDTH-1:0]  m_drive_value
);

    localparam int CW = (DATA_WIDTH > OUT_WIDTH ? DATA_WIDTH : OUT_WIDTH) + 2;
    localparam logic signed [CW-1:0] VMAX_X =
        {{(CW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [CW-1:0] VMIN_X = ~VMAX_X;
    localparam logic signed [CW-1:0] OMAX_X =
        {{(CW-OUT_WIDTH+1){1'b0}}, {(OUT_WIDTH-1){1'b1}}};
    localparam logic signed [CW-1:0] OMIN_X = ~OMAX_X;

    function automatic logic signed [DATA_WIDTH-1:0] sat_w(input logic signed [CW-1:0] x);
        logic signed [DATA_WIDTH-1:0] r;
        if (x > VMAX_X) begin
            r = VMAX_X[DATA_WIDTH-1:0];
        end else if (x < VMIN_X) begin
            r = VMIN_X[DATA_WIDTH-1:0];
        end else begin
            r = x[DATA_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [OUT_WIDTH-1:0] sat_out(input logic signed [CW-1:0] x);
        logic signed [OUT_WIDTH-1:0] r;
        if (x > OMAX_X) begin
            r = OMAX_X[OUT_WIDTH-1:0];
        end else if (x < OMIN_X) begin
            r = OMIN_X[OUT_WIDTH-1:0];
        end else begin
            r = x[OUT_WIDTH-1:0];
        end
        return r;
    endfunction

    logic signed [DATA_WIDTH-1:0] integral_reg;
    logic                         m_valid_reg;
    logic signed [OUT_WIDTH-1:0]  drive_reg;
    logic signed [DATA_WIDTH-1:0] integral_sum;
    logic signed [DATA_WIDTH-1:0] integral_next;
    logic signed [DATA_WIDTH-1:0] pd_sum;
    logic signed [DATA_WIDTH-1:0] drive_sum;
    logic signed [CW-1:0]         limit_x;
    logic signed [OUT_WIDTH-1:0]  drive_next;
    logic                         load;

    assign in_ready = !m_valid_reg || m_ready;
    assign load     = in_ready && in_ctl.valid;
    assign limit_x  = CW'($signed({1'b0, int_limit}));

    always_comb begin
        integral_sum = sat_w(CW'(integral_reg) + CW'(i_term));
        if (CW'(integral_sum) > limit_x) begin
            integral_next = limit_x[DATA_WIDTH-1:0];
        end else if (CW'(integral_sum) < -limit_x) begin
            integral_next = DATA_WIDTH'(-limit_x);
        end else begin
            integral_next = integral_sum;
        end
        pd_sum     = in_ctl.d_en ? sat_w(CW'(p_term) + CW'(d_term)) : p_term;
        drive_sum  = use_i_term ? sat_w(CW'(pd_sum) + CW'(integral_next)) : pd_sum;
        drive_next = sat_out(CW'(drive_sum));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            integral_reg <= '0;
        end else begin
            if (in_ready) begin
                m_valid_reg <= in_ctl.valid && !in_ctl.reset_op;
            end
            if (load) begin
                if (in_ctl.reset_op) begin
                    integral_reg <= '0;
                end else if (use_i_term) begin
                    integral_reg <= integral_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            drive_reg <= drive_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_drive_value = drive_reg;

endmodule

@@ design/pid_checker.sv @@
// Port-level checker for pid_controller_step and its bind
`include "pid_controller_step_macros.svh"

module pid_checker
    import pid_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic signed [OUT_WIDTH-1:0] m_drive_value,
    input logic                       cfg_ready
);

    `PID_ASSERT_ALWAYS(a_reset_drops_result, !aresetn |=> !m_valid, "result beat after reset")
    `PID_ASSERT(a_cfg_always_ready, cfg_ready, "configuration port not ready")
    `PID_ASSERT(a_stall_only_when_full, !s_ready |-> (m_valid && !m_ready), "early stall")
    `PID_ASSERT(a_result_kept, (m_valid && !m_ready) |=> m_valid, "stalled beat dropped")
    `PID_ASSERT(a_payload_kept, (m_valid && !m_ready) |=> $stable(m_drive_value), "beat changed")

endmodule

bind pid_controller_step pid_checker u_pid_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_drive_value(m_drive_value),
    .cfg_ready    (cfg_ready)
);
